### hdl/pixel_hit_cluster_window_assert.svh
// Assertion macros shared by the cluster window RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PIXEL_HIT_CLUSTER_WINDOW_ASSERT_SVH
`define PIXEL_HIT_CLUSTER_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PHCW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication.
`define PHCW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define PHCW_ASSERT_IMP(lbl, ante, cons)
`define PHCW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hdl/phcw_pkg.sv
package phcw_pkg;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 9;
	localparam int XING_W = 5;
	localparam int SPAN_W = 10;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Detector bounds.
	localparam int unsigned NUM_COLUMNS  = 80;
	localparam int unsigned NUM_ROWS     = 336;
	localparam int unsigned NUM_TRIGGERS = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COL_REACH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_REACH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XING_REACH = 2'd2;

	// Input action codes.
	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	typedef struct packed {
		logic [2:0] col;
		logic [3:0] row;
		logic [1:0] xing;
	} reach_t;

	typedef struct packed {
		logic [COL_W-1:0]  col_lo;
		logic [COL_W-1:0]  col_hi;
		logic [ROW_W-1:0]  row_lo;
		logic [ROW_W-1:0]  row_hi;
		logic [XING_W-1:0] xing_lo;
		logic [XING_W-1:0] xing_hi;
		logic              xing_fixed;
	} window_t;

	typedef struct packed {
		logic              action;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [XING_W-1:0] xing;
	} hit_t;

	typedef struct packed {
		logic    accepted;
		logic    error;
		window_t win;
	} result_t;

endpackage

### hdl/phcw_cfg_regs.sv
module phcw_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [phcw_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [phcw_pkg::CFG_DATA_W-1:0] wr_data,
	output phcw_pkg::reach_t               reach
);
	import phcw_pkg::*;

	reach_t reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q.col  <= 3'd1;
			reach_q.row  <= 4'd2;
			reach_q.xing <= 2'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_COL_REACH:  reach_q.col  <= wr_data[2:0];
				CFG_ROW_REACH:  reach_q.row  <= wr_data[3:0];
				CFG_XING_REACH: reach_q.xing <= wr_data[1:0];
				default: begin
					// Writes past the register list are dropped.
				end
			endcase
		end
	end

	assign reach = reach_q;

endmodule

### hdl/phcw_window_update.sv
module phcw_window_update (
	input  phcw_pkg::window_t win,
	input  phcw_pkg::reach_t  reach,
	input  phcw_pkg::hit_t    hit,
	output phcw_pkg::result_t res
);
	import phcw_pkg::*;

	localparam logic [SPAN_W-1:0] COL_BOUND  = SPAN_W'(NUM_COLUMNS);
	localparam logic [SPAN_W-1:0] ROW_BOUND  = SPAN_W'(NUM_ROWS);
	localparam logic [SPAN_W-1:0] XING_BOUND = SPAN_W'(NUM_TRIGGERS);

	typedef struct packed {
		logic [SPAN_W-1:0] lo;
		logic [SPAN_W-1:0] hi;
	} span_t;

	// x + r, saturating at the bound.
	function automatic logic [SPAN_W-1:0] sat_up(input logic [SPAN_W-1:0] x,
			input logic [SPAN_W-1:0] r, input logic [SPAN_W-1:0] bound);
		logic [SPAN_W:0] s;
		s = {1'b0, x} + {1'b0, r};
		return (s > {1'b0, bound}) ? bound : s[SPAN_W-1:0];
	endfunction

	// x - r, saturating at zero and at the bound.
	function automatic logic [SPAN_W-1:0] sat_down(input logic [SPAN_W-1:0] x,
			input logic [SPAN_W-1:0] r, input logic [SPAN_W-1:0] bound);
		logic [SPAN_W-1:0] d;
		d = x - r;
		if (x < r)
			return '0;
		return (d > bound) ? bound : d;
	endfunction

	// Edge rule for rows and columns; v is known to lie within [lo, hi].
	function automatic span_t span_adjust(input logic [SPAN_W-1:0] v,
			input logic [SPAN_W-1:0] r, input logic [SPAN_W-1:0] bound,
			input span_t cur);
		span_t             nxt;
		logic [SPAN_W-1:0] dlo;
		logic [SPAN_W-1:0] dhi;
		nxt = cur;
		dlo = v - cur.lo;
		dhi = cur.hi - v;
		if (v == cur.hi) begin
			nxt.hi = sat_up(cur.hi, r, bound);
		end else if (v == cur.lo) begin
			nxt.lo = sat_down(cur.lo, r, bound);
		end else if (dlo > dhi) begin
			if (dhi <= r)
				nxt.hi = sat_up(v, r, bound);
		end else if (dlo < dhi) begin
			if (dlo <= r)
				nxt.lo = sat_down(v, r, bound);
		end
		return nxt;
	endfunction

	logic [SPAN_W-1:0] col_v, row_v, xing_v;
	logic [SPAN_W-1:0] col_r, row_r, xing_r;
	logic              hit_in_win;
	span_t             col_span, row_span;
	logic [XING_W:0]   xing_lo_up;
	window_t           nxt;

	assign col_v  = SPAN_W'(hit.col);
	assign row_v  = SPAN_W'(hit.row);
	assign xing_v = SPAN_W'(hit.xing);
	assign col_r  = SPAN_W'(reach.col);
	assign row_r  = SPAN_W'(reach.row);
	assign xing_r = SPAN_W'(reach.xing);

	assign hit_in_win = (hit.col >= win.col_lo) && (hit.col <= win.col_hi) &&
		(hit.row >= win.row_lo) && (hit.row <= win.row_hi) &&
		(hit.xing >= win.xing_lo) && (hit.xing <= win.xing_hi);

	assign col_span = span_adjust(col_v, col_r, COL_BOUND,
		'{lo: SPAN_W'(win.col_lo), hi: SPAN_W'(win.col_hi)});
	assign row_span = span_adjust(row_v, row_r, ROW_BOUND,
		'{lo: SPAN_W'(win.row_lo), hi: SPAN_W'(win.row_hi)});

	assign xing_lo_up = {1'b0, win.xing_lo} + (XING_W+1)'(reach.xing);

	always_comb begin
		nxt          = win;
		res.accepted = 1'b0;
		res.error    = 1'b0;
		if (hit.action == ACT_SEED) begin
			if (xing_v > XING_BOUND) begin
				res.error = 1'b1;
			end else begin
				res.accepted   = 1'b1;
				nxt.col_hi     = COL_W'(sat_up(col_v, col_r, COL_BOUND));
				nxt.col_lo     = COL_W'(sat_down(col_v, col_r, COL_BOUND));
				nxt.row_hi     = ROW_W'(sat_up(row_v, row_r, ROW_BOUND));
				nxt.row_lo     = ROW_W'(sat_down(row_v, row_r, ROW_BOUND));
				nxt.xing_hi    = XING_W'(sat_up(xing_v, xing_r, XING_BOUND));
				nxt.xing_lo    = XING_W'(sat_down(xing_v, xing_r, XING_BOUND));
				nxt.xing_fixed = 1'b0;
			end
		end else if (hit_in_win) begin
			res.accepted = 1'b1;
			nxt.col_lo   = COL_W'(col_span.lo);
			nxt.col_hi   = COL_W'(col_span.hi);
			nxt.row_lo   = ROW_W'(row_span.lo);
			nxt.row_hi   = ROW_W'(row_span.hi);
			// The crossing edges move at most once per cluster.
			if (!win.xing_fixed) begin
				if (hit.xing == win.xing_hi) begin
					if (hit.xing != '0) begin
						if (SPAN_W'(xing_lo_up) <= XING_BOUND)
							nxt.xing_lo = XING_W'(xing_lo_up);
						nxt.xing_fixed = 1'b1;
					end
				end else if (hit.xing == win.xing_lo) begin
					if ((SPAN_W'(win.xing_hi) != XING_BOUND) &&
							((win.xing_hi < XING_W'(reach.xing)) ||
							((win.xing_hi - XING_W'(reach.xing)) != win.xing_lo)))
						nxt.xing_hi = XING_W'(sat_down(SPAN_W'(win.xing_hi), xing_r,
							XING_BOUND));
					nxt.xing_fixed = 1'b1;
				end
			end
		end
		res.win = nxt;
	end

endmodule

### hdl/pixel_hit_cluster_window.sv
// Pixel cluster acceptance window tracker.
// A beat accepted at the input is registered, evaluated against the window state
// and its result is registered in the output register. One hit per cycle is
// taken while the output is not stalled; the window state updates with each result.
// Reset (arst_n low, asynchronous) clears the window and all valid flags and
// loads the reach registers with 1, 2 and 1.
module pixel_hit_cluster_window (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [phcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phcw_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [phcw_pkg::COL_W-1:0]      hit_col,
	input  logic [phcw_pkg::ROW_W-1:0]      hit_row,
	input  logic [phcw_pkg::XING_W-1:0]     hit_crossing,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic                           error,
	output logic [phcw_pkg::COL_W-1:0]      win_col_low,
	output logic [phcw_pkg::COL_W-1:0]      win_col_high,
	output logic [phcw_pkg::ROW_W-1:0]      win_row_low,
	output logic [phcw_pkg::ROW_W-1:0]      win_row_high,
	output logic [phcw_pkg::XING_W-1:0]     win_crossing_low,
	output logic [phcw_pkg::XING_W-1:0]     win_crossing_high
);
	import phcw_pkg::*;

	`include "pixel_hit_cluster_window_assert.svh"

	// Configuration writes are always taken; only the user ensures the block is idle.
	reach_t reach;

	assign cfg_ready = 1'b1;

	phcw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.reach    (reach)
	);

	// Input register. It holds one beat; it is evaluated against the window
	// state in the cycle the output register can take the result, so a
	// stalled output never blocks a beat already in flight from being held.
	hit_t    hit_s1;
	logic    valid_s1;
	logic    advance;
	window_t win_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hit_s1 <= '{action: action, col: hit_col, row: hit_row, xing: hit_crossing};
		end
	end

	phcw_window_update u_update (
		.win   (win_q),
		.reach (reach),
		.hit   (hit_s1),
		.res   (res)
	);

	// Window state moves only when the evaluated beat is handed to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= res.win;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted          = res_q.accepted;
	assign error             = res_q.error;
	assign win_col_low       = res_q.win.col_lo;
	assign win_col_high      = res_q.win.col_hi;
	assign win_row_low       = res_q.win.row_lo;
	assign win_row_high      = res_q.win.row_hi;
	assign win_crossing_low  = res_q.win.xing_lo;
	assign win_crossing_high = res_q.win.xing_hi;

	// A seed error and an acceptance never come in the same result.
	`PHCW_ASSERT_IMP(a_err_excl, out_valid_q, !(res_q.accepted && res_q.error))
	// Window edges never pass the detector bounds.
	`PHCW_ASSERT_IMP(a_bounds, out_valid_q, (res_q.win.col_hi <= COL_W'(NUM_COLUMNS)) && (res_q.win.row_hi <= ROW_W'(NUM_ROWS)) && (res_q.win.xing_hi <= XING_W'(NUM_TRIGGERS)))
	// The input side stalls only when a beat is held behind a stalled result.
	`PHCW_ASSERT_IMP(a_stall, !in_ready, valid_s1 && out_valid_q && !out_ready)
	// A rejected seed leaves the window untouched.
	`PHCW_ASSERT_NXT(a_err_hold, advance && res.error, win_q == $past(win_q))

endmodule

### tb/pixel_hit_cluster_window_checker.sv
`timescale 1ns / 1ps

module pixel_hit_cluster_window_checker (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [phcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phcw_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            action,
	input  logic [phcw_pkg::COL_W-1:0]      hit_col,
	input  logic [phcw_pkg::ROW_W-1:0]      hit_row,
	input  logic [phcw_pkg::XING_W-1:0]     hit_crossing,

	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            accepted,
	input  logic                            error,
	input  logic [phcw_pkg::COL_W-1:0]      win_col_low,
	input  logic [phcw_pkg::COL_W-1:0]      win_col_high,
	input  logic [phcw_pkg::ROW_W-1:0]      win_row_low,
	input  logic [phcw_pkg::ROW_W-1:0]      win_row_high,
	input  logic [phcw_pkg::XING_W-1:0]     win_crossing_low,
	input  logic [phcw_pkg::XING_W-1:0]     win_crossing_high,

	output int                              fail_count,
	output int                              outstanding
);
	import phcw_pkg::*;

	typedef struct packed {
		logic              accepted;
		logic              error;
		logic [COL_W-1:0]  col_low;
		logic [COL_W-1:0]  col_high;
		logic [ROW_W-1:0]  row_low;
		logic [ROW_W-1:0]  row_high;
		logic [XING_W-1:0] xing_low;
		logic [XING_W-1:0] xing_high;
	} window_beat_t;

	localparam int COL_BOUND  = int'(NUM_COLUMNS);
	localparam int ROW_BOUND  = int'(NUM_ROWS);
	localparam int XING_BOUND = int'(NUM_TRIGGERS);

	// Shadow copy of the window and the reach registers.
	int col_lo, col_hi, row_lo, row_hi, xing_lo, xing_hi;
	bit xing_fixed;
	int col_step, row_step, xing_step;

	window_beat_t window_q[$];
	int mismatches = 0;

	assign fail_count = mismatches;

	function automatic int clamp_to(int v, int bound);
		if (v < 0)
			return 0;
		if (v > bound)
			return bound;
		return v;
	endfunction

	// Row and column edges follow the same growth rule.
	function automatic void adjust_span(input int v, input int step, input int bound,
			inout int lo, inout int hi);
		int d_lo, d_hi;
		d_lo = v - lo;
		d_hi = hi - v;
		if (v == hi) begin
			hi = clamp_to(hi + step, bound);
		end else if (v < hi && v == lo) begin
			lo = clamp_to(lo - step, bound);
		end else if (v < hi && v > lo) begin
			if (d_lo > d_hi && d_hi <= step)
				hi = clamp_to(v + step, bound);
			else if (d_lo < d_hi && d_lo <= step)
				lo = clamp_to(v - step, bound);
		end
	endfunction

	function automatic void adjust_crossing(int b);
		if (b == xing_hi) begin
			if (b != 0) begin
				if (xing_lo + xing_step <= XING_BOUND)
					xing_lo = xing_lo + xing_step;
				xing_fixed = 1'b1;
			end
		end else if (b < xing_hi && b == xing_lo) begin
			if (xing_hi != XING_BOUND && xing_hi - xing_step != xing_lo)
				xing_hi = clamp_to(xing_hi - xing_step, XING_BOUND);
			xing_fixed = 1'b1;
		end
	endfunction

	function automatic window_beat_t predict_window(logic act, int c, int r, int b);
		window_beat_t res;
		res = '0;
		if (act == ACT_SEED) begin
			if (b > XING_BOUND) begin
				res.error = 1'b1;
			end else begin
				col_hi     = clamp_to(c + col_step, COL_BOUND);
				col_lo     = clamp_to(c - col_step, COL_BOUND);
				row_hi     = clamp_to(r + row_step, ROW_BOUND);
				row_lo     = clamp_to(r - row_step, ROW_BOUND);
				xing_hi    = clamp_to(b + xing_step, XING_BOUND);
				xing_lo    = clamp_to(b - xing_step, XING_BOUND);
				xing_fixed = 1'b0;
				res.accepted = 1'b1;
			end
		end else if (c >= col_lo && c <= col_hi && r >= row_lo && r <= row_hi &&
				b >= xing_lo && b <= xing_hi) begin
			res.accepted = 1'b1;
			if (!xing_fixed)
				adjust_crossing(b);
			adjust_span(r, row_step, ROW_BOUND, row_lo, row_hi);
			adjust_span(c, col_step, COL_BOUND, col_lo, col_hi);
		end
		res.col_low   = col_lo[COL_W-1:0];
		res.col_high  = col_hi[COL_W-1:0];
		res.row_low   = row_lo[ROW_W-1:0];
		res.row_high  = row_hi[ROW_W-1:0];
		res.xing_low  = xing_lo[XING_W-1:0];
		res.xing_high = xing_hi[XING_W-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		window_beat_t want;
		if (!arst_n) begin
			col_step   = 1;
			row_step   = 2;
			xing_step  = 1;
			col_lo     = 0;
			col_hi     = 0;
			row_lo     = 0;
			row_hi     = 0;
			xing_lo    = 0;
			xing_hi    = 0;
			xing_fixed = 1'b0;
			window_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COL_REACH:  col_step  = int'(cfg_data[2:0]);
					CFG_ROW_REACH:  row_step  = int'(cfg_data[3:0]);
					CFG_XING_REACH: xing_step = int'(cfg_data[1:0]);
					default: ;
				endcase
			end
			// Results leave before this edge's hit is predicted, so the oldest
			// expectation is always the one compared.
			if (out_valid && out_ready) begin
				if (window_q.size() == 0) begin
					$error("result beat arrived with no hit waiting");
					mismatches++;
				end else begin
					want = window_q.pop_front();
					check_field("accepted", 10'(want.accepted), 10'(accepted));
					check_field("error", 10'(want.error), 10'(error));
					check_field("win_col_low", 10'(want.col_low), 10'(win_col_low));
					check_field("win_col_high", 10'(want.col_high), 10'(win_col_high));
					check_field("win_row_low", 10'(want.row_low), 10'(win_row_low));
					check_field("win_row_high", 10'(want.row_high), 10'(win_row_high));
					check_field("win_crossing_low", 10'(want.xing_low),
						10'(win_crossing_low));
					check_field("win_crossing_high", 10'(want.xing_high),
						10'(win_crossing_high));
				end
			end
			if (in_valid && in_ready)
				window_q = {window_q, predict_window(action, int'(hit_col),
					int'(hit_row), int'(hit_crossing))};
			outstanding <= window_q.size();
		end
	end

endmodule

### tb/tb_pixel_hit_cluster_window.sv
`timescale 1ns / 1ps

module tb_pixel_hit_cluster_window;
	import phcw_pkg::*;

	// The run is split into a directed part under the reset reaches and a
	// number of random phases, each with its own reach setting.
	localparam int NUM_PHASES      = 5;
	localparam int ITEMS_PER_PHASE = 100;
	// Long receiver hold-off, started once after this many result beats.
	localparam int HOLD_AT_BEAT    = 150;
	localparam int LONG_HOLD       = 120;
	// Cycles without any beat on any channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT  = 2000;

	logic                  clk;
	logic                  arst_n;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [COL_W-1:0]      hit_col;
	logic [ROW_W-1:0]      hit_row;
	logic [XING_W-1:0]     hit_crossing;

	logic                  out_valid;
	logic                  out_ready;
	logic                  accepted;
	logic                  error;
	logic [COL_W-1:0]      win_col_low;
	logic [COL_W-1:0]      win_col_high;
	logic [ROW_W-1:0]      win_row_low;
	logic [ROW_W-1:0]      win_row_high;
	logic [XING_W-1:0]     win_crossing_low;
	logic [XING_W-1:0]     win_crossing_high;

	int fail_count;
	int outstanding;

	// Set for the last phase: from then on neither side idles.
	logic no_idle;

	// Reaches currently programmed; written to the block and used to aim test hits near the window.
	int reach_col, reach_row, reach_xing;

	int quiet_cycles = 0;

	pixel_hit_cluster_window u_dut (.*);

	pixel_hit_cluster_window_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: any beat on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL pixel_hit_cluster_window");
			$finish;
		end
	end

	// Offer one hit and hold it until the block takes the beat. Sometimes a
	// random gap comes first, so gaps land at every point of the window update.
	task automatic send_hit(logic act, int c, int r, int b);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		hit_col      <= c[COL_W-1:0];
		hit_row      <= r[ROW_W-1:0];
		hit_crossing <= b[XING_W-1:0];
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted result has been seen.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	// A point near the given center, clipped to the field's range.
	function automatic int scatter(int center, int spread, int top);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	// Most random traffic is a seed followed by a burst of hits around it, so
	// the window actually grows and tightens; the rest is unaimed noise.
	task automatic run_random(int quota);
		int sent, seed_c, seed_r, seed_x, n_tests, k;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 7) == 0) begin
				send_hit($urandom_range(0, 1) == 1, $urandom_range(0, 127),
					$urandom_range(0, 511), $urandom_range(0, 31));
				sent++;
			end else begin
				if ($urandom_range(0, 7) == 0)
					seed_c = $urandom_range(0, 127);
				else
					seed_c = $urandom_range(0, NUM_COLUMNS);
				if ($urandom_range(0, 7) == 0)
					seed_r = $urandom_range(0, 511);
				else
					seed_r = $urandom_range(0, NUM_ROWS);
				// An occasional seed outside the trigger range must be refused.
				if ($urandom_range(0, 7) == 0)
					seed_x = $urandom_range(NUM_TRIGGERS + 1, 31);
				else
					seed_x = $urandom_range(0, NUM_TRIGGERS);
				send_hit(ACT_SEED, seed_c, seed_r, seed_x);
				sent++;
				n_tests = $urandom_range(2, 12);
				for (k = 0; k < n_tests; k++) begin
					send_hit(ACT_TEST, scatter(seed_c, 3 * reach_col + 2, 127),
						scatter(seed_r, 3 * reach_row + 2, 511),
						scatter(seed_x, 2 * reach_xing + 1, 31));
					sent++;
				end
			end
		end
	endtask

	// Result side. Random stalls, plus one long hold-off
	// that lets the block fill up and push back on the hit stream.
	initial begin : drain_side
		int beats;
		bit held;
		beats = 0;
		held  = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				beats++;
			if (beats == HOLD_AT_BEAT && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int p;
		arst_n = 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_COL_REACH;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		action       <= ACT_SEED;
		hit_col      <= '0;
		hit_row      <= '0;
		hit_crossing <= '0;
		no_idle      <= 1'b0;
		reach_col  = 1;
		reach_row  = 2;
		reach_xing = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset reaches (1, 2, 1).
		// Before any seed the window is a single point at the origin.
		send_hit(ACT_TEST, 0, 0, 0);
		send_hit(ACT_TEST, 1, 0, 0);
		// Seeds with a crossing past the trigger count raise an error.
		send_hit(ACT_SEED, 20, 20, NUM_TRIGGERS + 1);
		send_hit(ACT_SEED, 20, 20, 31);
		// Seed at the origin: low edges clamp to zero.
		send_hit(ACT_SEED, 0, 0, 0);
		// Seed beyond the column and row bounds, then hits against it.
		send_hit(ACT_SEED, 127, 511, NUM_TRIGGERS);
		send_hit(ACT_TEST, 127, 511, NUM_TRIGGERS);
		send_hit(ACT_TEST, NUM_COLUMNS, NUM_ROWS, NUM_TRIGGERS);
		// A mid-detector cluster: edge hits, near-edge hits inside, an
		// equidistant hit, a one-time crossing step, and a miss.
		send_hit(ACT_SEED, 40, 100, 8);
		send_hit(ACT_TEST, 41, 100, 8);
		send_hit(ACT_TEST, 40, 102, 9);
		send_hit(ACT_TEST, 40, 98, 8);
		send_hit(ACT_TEST, 40, 103, 8);
		send_hit(ACT_TEST, 40, 97, 8);
		send_hit(ACT_TEST, 43, 100, 8);
		// Crossing low edge tightens the high edge.
		send_hit(ACT_SEED, 10, 50, 5);
		send_hit(ACT_TEST, 10, 50, 4);
		// Crossing high edge pinned at the trigger count: no tightening.
		send_hit(ACT_SEED, 10, 50, NUM_TRIGGERS);
		send_hit(ACT_TEST, 10, 50, NUM_TRIGGERS - 1);
		// Near the upper bounds: the step would land on the low edge, and the
		// row and column high edges saturate.
		send_hit(ACT_SEED, NUM_COLUMNS - 1, NUM_ROWS - 1, 0);
		send_hit(ACT_TEST, NUM_COLUMNS - 1, NUM_ROWS - 1, 0);
		send_hit(ACT_TEST, NUM_COLUMNS, NUM_ROWS, 1);
		send_hit(ACT_TEST, NUM_COLUMNS, NUM_ROWS, 0);
		drain_results();

		// Random phases: the first two take the extreme reaches, the rest random
		// ones. The block is idle at each reprogramming.
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				no_idle <= 1'b1;
			if (p == 0) begin
				reach_col  = 0;
				reach_row  = 0;
				reach_xing = 0;
			end else if (p == 1) begin
				reach_col  = 7;
				reach_row  = 15;
				reach_xing = 3;
			end else begin
				reach_col  = $urandom_range(0, 7);
				reach_row  = $urandom_range(0, 15);
				reach_xing = $urandom_range(0, 3);
			end
			cfg_put(CFG_COL_REACH, reach_col);
			cfg_put(CFG_ROW_REACH, reach_row);
			cfg_put(CFG_XING_REACH, reach_xing);
			cfg_valid <= 1'b0;
			run_random(ITEMS_PER_PHASE);
			drain_results();
		end

		// Give any stray result a chance to show up before the verdict.
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASS pixel_hit_cluster_window");
		else
			$display("FAIL pixel_hit_cluster_window");
		$finish;
	end

endmodule
